[rtl/k2rgb_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// k2rgb_pkg
// Shared widths and fixed-point fit constants for the colour temperature
// converter.
// ---------------------------------------------------------------------------
package k2rgb_pkg;

  localparam int LG_W   = 28;
  localparam int Y_W    = 26;
  localparam int FIT_W  = 28;
  localparam int EXP_W  = 25;
  localparam int NTERMS = 20;

  localparam logic [15:0] T_MIN       = 16'd1000;
  localparam logic [15:0] T_MAX       = 16'd40000;
  localparam logic [15:0] T_KNEE      = 16'd6600;
  localparam logic [15:0] T_BLUE_OFF  = 16'd1900;
  localparam logic [15:0] T_POW_SHIFT = 16'd6000;
  localparam logic [15:0] T_LOG_SHIFT = 16'd1000;

  localparam logic [63:0] ONE_Q24 = 64'd16777216;
  localparam logic [63:0] LN2_Q30 = (64'd693147181 << 30) / 64'd1000000000;

  localparam logic [63:0] RED_C = (64'd329698727446 * 64'd16777216 / 64'd1000000000)
                                  / 64'd255;
  localparam logic [63:0] RED_E = 64'd133204759 * 64'd16777216 / 64'd1000000000;
  localparam logic [63:0] GRN_C = (64'd288122169528 * 64'd16777216 / 64'd1000000000)
                                  / 64'd255;
  localparam logic [63:0] GRN_E = 64'd75514849 * 64'd16777216 / 64'd1000000000;
  localparam logic [63:0] GRN_A =
      (((64'd99470802586 * 64'd16777216 / 64'd1000000000) * LN2_Q30) >> 30) / 64'd255;
  localparam logic [63:0] GRN_B = (64'd161119568166 * 64'd16777216 / 64'd1000000000)
                                  / 64'd255;
  localparam logic [63:0] BLU_A =
      (((64'd138517731223 * 64'd16777216 / 64'd1000000000) * LN2_Q30) >> 30) / 64'd255;
  localparam logic [63:0] BLU_B = (64'd305044792731 * 64'd16777216 / 64'd1000000000)
                                  / 64'd255;

  function automatic logic [63:0] log2q_c(input logic [63:0] n);
    logic [63:0] m;
    logic [63:0] r;
    int          p;
    p = 0;
    for (int i = 1; i < 16; i++) begin
      if (n[i]) p = i;
    end
    m = n << (30 - p);
    r = 64'(p) << 30;
    for (int i = 29; i >= 0; i--) begin
      m = (m * m) >> 30;
      if (m >= (64'd2 << 30)) begin
        m = m >> 1;
        r = r | (64'd1 << i);
      end
    end
    return r >> 6;
  endfunction

  localparam logic [LG_W-1:0] LOG2_100 = LG_W'(log2q_c(64'd100));

  typedef struct packed {
    logic knee_lo;
    logic blue_full;
    logic blue_zero;
  } flags_t;

endpackage

[rtl/k2rgb_temp_if.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// k2rgb_temp_if
// Valid/ready channel carrying one colour temperature in kelvin.
// ---------------------------------------------------------------------------
interface k2rgb_temp_if;
  logic        valid;
  logic        ready;
  logic [15:0] kelvin;

  modport source (output valid, output kelvin, input ready);
  modport sink (input valid, input kelvin, output ready);
endinterface

[rtl/k2rgb_color_if.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// k2rgb_color_if
// Valid/ready channel carrying one RGB colour code.
// ---------------------------------------------------------------------------
interface k2rgb_color_if #(parameter int COLOR_BITS = 8);
  logic                  valid;
  logic                  ready;
  logic [COLOR_BITS-1:0] red;
  logic [COLOR_BITS-1:0] green;
  logic [COLOR_BITS-1:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink (input valid, input red, input green, input blue, output ready);
endinterface

[rtl/k2rgb_log2.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// k2rgb_log2
// Pipelined base-two logarithm in Q24, one fraction bit per squaring stage.
// ---------------------------------------------------------------------------
module k2rgb_log2 #(
  parameter int SIDE_W = 3
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic [15:0]                 n,
  input  logic [SIDE_W-1:0]           side_in,
  output logic                        out_valid,
  output logic [k2rgb_pkg::LG_W-1:0]  lg,
  output logic [SIDE_W-1:0]           side_out
);
  import k2rgb_pkg::*;

  localparam int NS = 24;

  logic [3:0]  p;
  logic [30:0] m0;

  logic              v_q  [0:NS];
  logic [30:0]       m_q  [0:NS];
  logic [3:0]        p_q  [0:NS];
  logic [NS-1:0]     fr_q [0:NS];
  logic [SIDE_W-1:0] sd_q [0:NS];

  always_comb begin
    p = '0;
    for (int i = 1; i < 16; i++) begin
      if (n[i]) p = 4'(i);
    end
  end

  assign m0 = {15'd0, n} << (5'd30 - {1'b0, p});

  always_ff @(posedge clk) begin
    if (rst) begin
      v_q[0] <= 1'b0;
    end else if (en) begin
      v_q[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_q[0]  <= m0;
      p_q[0]  <= p;
      fr_q[0] <= '0;
      sd_q[0] <= side_in;
    end
  end

  for (genvar j = 0; j < NS; j++) begin : g_sq
    logic [61:0] sq;
    logic        hit;
    assign sq  = 62'(m_q[j]) * 62'(m_q[j]);
    assign hit = sq[61];

    always_ff @(posedge clk) begin
      if (rst) begin
        v_q[j+1] <= 1'b0;
      end else if (en) begin
        v_q[j+1] <= v_q[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        m_q[j+1]  <= hit ? sq[61:31] : sq[60:30];
        p_q[j+1]  <= p_q[j];
        fr_q[j+1] <= {fr_q[j][NS-2:0], hit};
        sd_q[j+1] <= sd_q[j];
      end
    end
  end

  assign out_valid = v_q[NS];
  assign lg        = {p_q[NS], fr_q[NS]};
  assign side_out  = sd_q[NS];
endmodule

[rtl/k2rgb_exp2.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// k2rgb_exp2
// Pipelined 2^-y in Q24: a series for the fraction, one term per two stages,
// then a shift by the integer part.
// ---------------------------------------------------------------------------
module k2rgb_exp2 #(
  parameter int SIDE_W = 59
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic [k2rgb_pkg::Y_W-1:0]   y,
  input  logic [SIDE_W-1:0]           side_in,
  output logic                        out_valid,
  output logic [k2rgb_pkg::EXP_W-1:0] e,
  output logic [SIDE_W-1:0]           side_out
);
  import k2rgb_pkg::*;

  logic              v0;
  logic [24:0]       g0;
  logic [1:0]        ip0;
  logic [SIDE_W-1:0] sd0;

  logic              va  [0:NTERMS];
  logic [30:0]       ta  [0:NTERMS];
  logic [31:0]       suma[0:NTERMS];
  logic [29:0]       ua  [0:NTERMS];
  logic [1:0]        ipa [0:NTERMS];
  logic [SIDE_W-1:0] sda [0:NTERMS];

  logic              ve;
  logic [EXP_W-1:0]  e_q;
  logic [SIDE_W-1:0] sde;

  logic [63:0] uprod;
  assign uprod = 64'(g0) * LN2_Q30;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0    <= 1'b0;
      va[0] <= 1'b0;
    end else if (en) begin
      v0    <= in_valid;
      va[0] <= v0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      g0      <= 25'(ONE_Q24) - {1'b0, y[23:0]};
      ip0     <= y[25:24];
      sd0     <= side_in;
      ua[0]   <= uprod[53:24];
      ta[0]   <= 31'd1 << 30;
      suma[0] <= 32'd1 << 30;
      ipa[0]  <= ip0;
      sda[0]  <= sd0;
    end
  end

  for (genvar gi = 0; gi < NTERMS; gi++) begin : g_term
    localparam logic [63:0] RK = ((64'd1 << 35) + 64'(gi + 1) - 64'd1) / 64'(gi + 1);

    logic              vm;
    logic [29:0]       xm;
    logic [31:0]       summ;
    logic [29:0]       um;
    logic [1:0]        ipm;
    logic [SIDE_W-1:0] sdm;
    logic [60:0]       tu;
    logic [65:0]       qx;

    assign tu = 61'(ta[gi]) * 61'(ua[gi]);
    assign qx = 66'(xm) * 66'(RK[35:0]);

    always_ff @(posedge clk) begin
      if (rst) begin
        vm       <= 1'b0;
        va[gi+1] <= 1'b0;
      end else if (en) begin
        vm       <= va[gi];
        va[gi+1] <= vm;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        xm         <= tu[59:30];
        summ       <= suma[gi];
        um         <= ua[gi];
        ipm        <= ipa[gi];
        sdm        <= sda[gi];
        ta[gi+1]   <= {1'b0, qx[64:35]};
        suma[gi+1] <= summ + {2'd0, qx[64:35]};
        ua[gi+1]   <= um;
        ipa[gi+1]  <= ipm;
        sda[gi+1]  <= sdm;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ve <= 1'b0;
    end else if (en) begin
      ve <= va[NTERMS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e_q <= EXP_W'(suma[NTERMS] >> (5'd7 + {3'd0, ipa[NTERMS]}));
      sde <= sda[NTERMS];
    end
  end

  assign out_valid = ve;
  assign e         = e_q;
  assign side_out  = sde;
endmodule

[rtl/kelvin_to_rgb_color.sv]
`timescale 1ns / 1ps
// Throughput: one temperature per cycle; the whole pipeline holds while a
// finished colour waits on the output and shifts again once it is taken.
// Reset clears every stage valid bit; data registers are not reset.
// ---------------------------------------------------------------------------
// kelvin_to_rgb_color
// Approximate blackbody RGB colour of a colour temperature, using log and
// power fits in Q24 fixed point through two log and two power pipelines.
// ---------------------------------------------------------------------------
module kelvin_to_rgb_color #(
  parameter int COLOR_BITS = 8
) (
  input  logic          clk,
  input  logic          rst,
  k2rgb_temp_if.sink    temp,
  k2rgb_color_if.source color
);
  import k2rgb_pkg::*;

  localparam int SIDE_W = 3 + 2 * FIT_W;
  localparam logic [COLOR_BITS-1:0] CODE_MAX = {COLOR_BITS{1'b1}};

  logic adv;
  logic vc;

  // Input stage.
  logic        v0;
  logic [15:0] xa0, xb0;
  flags_t      fl0;
  logic [15:0] tc;

  assign adv        = !vc || color.ready;
  assign temp.ready = adv;

  always_comb begin
    if (temp.kelvin < T_MIN) begin
      tc = T_MIN;
    end else if (temp.kelvin > T_MAX) begin
      tc = T_MAX;
    end else begin
      tc = temp.kelvin;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (adv) begin
      v0 <= temp.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      xa0           <= (tc > T_KNEE) ? tc - T_POW_SHIFT : tc;
      xb0           <= tc - T_LOG_SHIFT;
      fl0.knee_lo   <= tc <= T_KNEE;
      fl0.blue_full <= tc >= T_KNEE;
      fl0.blue_zero <= tc <= T_BLUE_OFF;
    end
  end

  // Logarithms.
  logic              vla, vlb;
  logic [LG_W-1:0]   la, lb;
  flags_t            fll;
  logic [2:0]        fl_unused;

  k2rgb_log2 #(.SIDE_W(3)) u_log_a (
    .clk(clk), .rst(rst), .en(adv), .in_valid(v0), .n(xa0), .side_in(fl0),
    .out_valid(vla), .lg(la), .side_out(fll)
  );

  k2rgb_log2 #(.SIDE_W(3)) u_log_b (
    .clk(clk), .rst(rst), .en(adv), .in_valid(v0), .n(xb0), .side_in(fl0),
    .out_valid(vlb), .lg(lb), .side_out(fl_unused)
  );

  // Fit front end.
  logic            v1, v2, v3;
  logic [LG_W-1:0] lga1, lgb1;
  flags_t          fl1, fl2, fl3;
  logic [63:0]     pyr, pyg, pmg, pmb;
  logic [Y_W-1:0]  yr2, yg2, yr3, yg3;
  logic [FIT_W-1:0] mg2, mb2, gf3, bf3;

  assign pyr = 64'(lga1) * RED_E;
  assign pyg = 64'(lga1) * GRN_E;
  assign pmg = 64'(lga1) * GRN_A;
  assign pmb = 64'(lgb1) * BLU_A;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (adv) begin
      v1 <= vla & vlb;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      lga1 <= la - LOG2_100;
      lgb1 <= lb - LOG2_100;
      fl1  <= fll;
      yr2  <= pyr[24 +: Y_W];
      yg2  <= pyg[24 +: Y_W];
      mg2  <= pmg[24 +: FIT_W];
      mb2  <= pmb[24 +: FIT_W];
      fl2  <= fl1;
      yr3  <= yr2;
      yg3  <= yg2;
      gf3  <= (64'(mg2) > GRN_B) ? mg2 - FIT_W'(GRN_B) : '0;
      bf3  <= (64'(mb2) > BLU_B) ? mb2 - FIT_W'(BLU_B) : '0;
      fl3  <= fl2;
    end
  end

  // Powers.
  logic              ver, veg;
  logic [EXP_W-1:0]  er, eg;
  logic [SIDE_W-1:0] sde, sde_unused;

  k2rgb_exp2 #(.SIDE_W(SIDE_W)) u_exp_r (
    .clk(clk), .rst(rst), .en(adv), .in_valid(v3), .y(yr3),
    .side_in({fl3, gf3, bf3}),
    .out_valid(ver), .e(er), .side_out(sde)
  );

  k2rgb_exp2 #(.SIDE_W(SIDE_W)) u_exp_g (
    .clk(clk), .rst(rst), .en(adv), .in_valid(v3), .y(yg3),
    .side_in({fl3, gf3, bf3}),
    .out_valid(veg), .e(eg), .side_out(sde_unused)
  );

  // Scale, select and code.
  logic             v4, v5;
  logic [63:0]      prr, prg;
  logic [25:0]      rp4, gp4;
  flags_t           fl4;
  logic [FIT_W-1:0] gf4, bf4;
  logic [24:0]      rv5, gv5, bv5;
  logic [25:0]      rs, gs;
  logic [FIT_W-1:0] bs;
  logic [COLOR_BITS-1:0] red_q, green_q, blue_q;
  logic [63:0]      cr, cg, cb;

  assign prr = 64'(er) * RED_C;
  assign prg = 64'(eg) * GRN_C;

  always_comb begin
    rs = fl4.knee_lo ? 26'(ONE_Q24) : rp4;
    gs = fl4.knee_lo ? 26'(gf4) : gp4;
    if (fl4.blue_full) begin
      bs = FIT_W'(ONE_Q24);
    end else if (fl4.blue_zero) begin
      bs = '0;
    end else begin
      bs = bf4;
    end
  end

  assign cr = 64'(rv5) * 64'(CODE_MAX) + (64'd1 << 23);
  assign cg = 64'(gv5) * 64'(CODE_MAX) + (64'd1 << 23);
  assign cb = 64'(bv5) * 64'(CODE_MAX) + (64'd1 << 23);

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
      v5 <= 1'b0;
      vc <= 1'b0;
    end else if (adv) begin
      v4 <= ver & veg;
      v5 <= v4;
      vc <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rp4     <= prr[49:24];
      gp4     <= prg[49:24];
      {fl4, gf4, bf4} <= sde;
      rv5     <= (64'(rs) > ONE_Q24) ? 25'(ONE_Q24) : rs[24:0];
      gv5     <= (64'(gs) > ONE_Q24) ? 25'(ONE_Q24) : gs[24:0];
      bv5     <= (64'(bs) > ONE_Q24) ? 25'(ONE_Q24) : bs[24:0];
      red_q   <= cr[24 +: COLOR_BITS];
      green_q <= cg[24 +: COLOR_BITS];
      blue_q  <= cb[24 +: COLOR_BITS];
    end
  end

  assign color.valid = vc;
  assign color.red   = red_q;
  assign color.green = green_q;
  assign color.blue  = blue_q;
endmodule
